FILE: design/ampi_pkg.sv
package ampi_pkg;

    // Base codes held in the base register; any other code parses as hexadecimal.
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_BIN = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_ONE   = 8'h31;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_MINUS = 8'h2d;

    // Offsets from '0' of the hex letter ranges, and what to subtract for the digit.
    localparam logic [7:0] HEX_UPPER_LO  = 8'h11;
    localparam logic [7:0] HEX_UPPER_HI  = 8'h16;
    localparam logic [7:0] HEX_LOWER_LO  = 8'h31;
    localparam logic [7:0] HEX_LOWER_HI  = 8'h36;
    localparam logic [7:0] HEX_UPPER_ADJ = 8'h07;
    localparam logic [7:0] HEX_LOWER_ADJ = 8'h27;
    localparam logic [7:0] DEC_MAX_DIGIT = 8'd9;

    localparam int OUT_WIDTH   = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_MINUS,
        KIND_DIGIT,
        KIND_BAD
    } kind_t;

    // One classified character on its way from the front end to the accumulator.
    typedef struct packed {
        kind_t      kind;
        logic [3:0] digit;
        logic [1:0] base;
        logic       last;
    } token_t;

endpackage

FILE: design/ampi_front.sv
module ampi_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_data,
    input  logic                  accept,
    input  logic [7:0]            char_code,
    input  logic                  char_present,
    input  logic                  is_last,
    output ampi_pkg::token_t      token
);
    import ampi_pkg::*;

    logic [1:0] base_reg;
    logic       first_reg;
    logic [7:0] offset;
    logic       digit_ok;
    logic [7:0] digit_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= BASE_DEC;
            first_reg <= 1'b1;
        end
        else
        begin
            if (cfg_valid)
            begin
                base_reg <= cfg_data;
            end
            if (accept)
            begin
                if (is_last)
                begin
                    first_reg <= 1'b1;
                end
                else if (char_present)
                begin
                    first_reg <= 1'b0;
                end
            end
        end
    end

    // Digit decode for the current base.
    always_comb
    begin
        offset      = char_code - ASCII_ZERO;
        digit_ok    = 1'b0;
        digit_value = offset;
        unique case (base_reg)
            BASE_DEC:
            begin
                digit_ok = (char_code >= ASCII_ZERO) && (char_code <= ASCII_NINE);
            end
            BASE_BIN:
            begin
                digit_ok = (char_code == ASCII_ZERO) || (char_code == ASCII_ONE);
            end
            default:
            begin
                if (char_code >= ASCII_ZERO)
                begin
                    if (offset <= DEC_MAX_DIGIT)
                    begin
                        digit_ok = 1'b1;
                    end
                    else if (offset >= HEX_UPPER_LO && offset <= HEX_UPPER_HI)
                    begin
                        digit_ok    = 1'b1;
                        digit_value = offset - HEX_UPPER_ADJ;
                    end
                    else if (offset >= HEX_LOWER_LO && offset <= HEX_LOWER_HI)
                    begin
                        digit_ok    = 1'b1;
                        digit_value = offset - HEX_LOWER_ADJ;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        token.digit = digit_value[3:0];
        token.base  = base_reg;
        token.last  = is_last;
        priority if (!char_present)
        begin
            token.kind = KIND_NONE;
        end
        else if (first_reg && char_code == ASCII_MINUS)
        begin
            token.kind = KIND_MINUS;
        end
        else if (digit_ok)
        begin
            token.kind = KIND_DIGIT;
        end
        else
        begin
            token.kind = KIND_BAD;
        end
    end

endmodule

FILE: design/ampi_queue.sv
module ampi_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ampi_pkg::token_t      push_token,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output ampi_pkg::token_t      head
);
    import ampi_pkg::*;

    token_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic [QUEUE_AW:0]     count_next;

    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

FILE: design/ampi_back.sv
module ampi_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  ampi_pkg::token_t                 q_head,
    output logic                             q_pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ampi_pkg::OUT_WIDTH-1:0]   out_value,
    output logic                             out_invalid
);
    import ampi_pkg::*;

    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] acc_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic                   err_reg;
    logic                   err_next;
    logic [VALUE_WIDTH-1:0] scaled;
    logic [VALUE_WIDTH-1:0] result;
    logic [63:0]            result_wide;
    logic                   out_valid_reg;
    logic [OUT_WIDTH-1:0]   out_value_reg;
    logic                   out_invalid_reg;

    // A non-final token never waits; a final one needs the output register free.
    assign q_pop = !q_empty && (!q_head.last || !out_valid_reg || out_ready);

    always_comb
    begin
        unique case (q_head.base)
            BASE_DEC: scaled = (acc_reg << 3) + (acc_reg << 1);
            BASE_BIN: scaled = acc_reg << 1;
            default:  scaled = acc_reg << 4;
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        neg_next = neg_reg;
        err_next = err_reg;
        if (!err_reg)
        begin
            unique case (q_head.kind)
                KIND_MINUS: neg_next = 1'b1;
                KIND_DIGIT: acc_next = scaled + VALUE_WIDTH'(q_head.digit);
                KIND_BAD:   err_next = 1'b1;
                default:    acc_next = acc_reg;
            endcase
        end
        if (err_next)
        begin
            result = '0;
        end
        else if (neg_next)
        begin
            result = '0 - acc_next;
        end
        else
        begin
            result = acc_next;
        end
        result_wide = 64'(result);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A new result may replace the one leaving in the same cycle.
            if (q_pop && q_head.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop)
            begin
                if (q_head.last)
                begin
                    acc_reg <= '0;
                    neg_reg <= 1'b0;
                    err_reg <= 1'b0;
                end
                else
                begin
                    acc_reg <= acc_next;
                    neg_reg <= neg_next;
                    err_reg <= err_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_head.last)
        begin
            out_value_reg   <= result_wide[OUT_WIDTH-1:0];
            out_invalid_reg <= err_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign out_invalid = out_invalid_reg;

endmodule

FILE: design/ascii_multibase_integer_parser.sv
// ASCII integer parser for decimal, binary and hexadecimal strings.
// The input stream carries one character per transaction: tdata is the ASCII
// code, tuser says whether the code is a real character (0 marks an empty
// item), and tlast closes the string. When the closing transaction has been
// parsed, one result transaction appears on the output stream: tdata is the
// value modulo 2^32 (negated when the string began with a minus sign, zero when
// the string held any character that is not a digit of the base) and tuser is
// the invalid flag. The base is set through the configuration channel and must
// only be changed while no string is in flight.
// The result of the closing input transaction passes through the queue entry and
// the output register. Throughput is one character per cycle while the queue is
// not full: the front end classifies each character as it arrives and the back end
// folds one digit per cycle with a single multiply-add by a constant.
// A four-entry queue sits between the classifier and the accumulator, so a
// stalled output receiver only holds back the closing item of a string; the
// input side keeps taking characters until the queue is full.
// Reset selects decimal, clears the accumulator and empties the queue and
// output register.
module ascii_multibase_integer_parser #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,       // base_select

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tuser,   // [0] char_present
    input  logic        s_axis_tlast,   // is_last

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] parsed_value
    output logic        m_axis_tuser    // [0] invalid
);
    import ampi_pkg::*;

    token_t front_token;
    token_t q_head;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;
    logic   in_accept;

    // Configuration writes are always taken; they land in the front end's base register.
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && !q_full;

    ampi_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .accept       (in_accept),
        .char_code    (s_axis_tdata),
        .char_present (s_axis_tuser),
        .is_last      (s_axis_tlast),
        .token        (front_token)
    );

    ampi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_accept),
        .push_token (front_token),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    ampi_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_value   (m_axis_tdata),
        .out_invalid (m_axis_tuser)
    );

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

// Testbench for ascii_multibase_integer_parser.
//
// Characters go in one input transaction at a time. An internal model of the
// parser follows every accepted transaction and keeps the same state as the
// block: the running value, the minus flag, the error flag and the start-of-
// string flag. At a closing transaction the model also queues the value and
// invalid flag that the output stream must deliver.
// A checking process compares each output transaction with the oldest queued
// result.
//
// The run has two parts. The first part is a short directed sequence. It
// covers the reset base, a lone minus, an empty string, a NUL character, a
// minus that is not the first character, an empty item before a leading
// minus, characters after an error, every base, both hex letter cases and
// the unused base code. The second part is six random phases that cover every
// base setting. Most strings are well formed with random digits, some of them long
// enough to overflow. Some strings have a bad character inserted, and a few
// are pure noise. In most phases one or both stream sides idle in random bursts.
// The last phase runs with no idling at all.
module tb;

    import ampi_pkg::*;

    // The package names three base codes; the fourth one parses as hex.
    localparam logic [1:0] BASE_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT    = 500000;
    localparam int DRAIN_CYCLES   = 8;      // well above the latency through queue and output register
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_ITEMS    = 305;

    typedef struct {
        logic [31:0] value;
        logic        invalid;
    } parse_result_t;

    typedef struct {
        logic [7:0] code;
        logic       present;
        logic       last;
    } char_item_t;

    logic        clk = 1'b0;
    logic        rst_n;

    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;

    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;      // [7:0] char_code
    logic        s_axis_tuser;      // [0] char_present
    logic        s_axis_tlast;      // is_last

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;      // [31:0] parsed_value
    logic        m_axis_tuser;      // [0] invalid

    // This is the model's copy of the block's state.
    logic [1:0]  model_base;
    logic [31:0] model_value;
    logic        model_negative;
    logic        model_error;
    logic        model_at_first;

    parse_result_t pending_results[$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  chars_sent = 0;
    int  stall_left = 0;
    bit  src_idle_en = 1'b0;
    bit  sink_stall_en = 1'b0;

    ascii_multibase_integer_parser DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The run is stopped if it hangs. This also covers a result that never
    // arrives while the end of the run waits for the queue to empty.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The result receiver stalls in random bursts while sink stalls are enabled.
    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        if (stall_left == 0 && sink_stall_en && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 11);
        m_axis_tready <= (stall_left == 0);
    end

    // Only the first few failures are printed; all of them are counted.
    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
    endtask

    // This process checks every output transaction against the oldest queued
    // result.
    always @(posedge clk)
    begin : check_results
        parse_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                note_failure($sformatf("unexpected result: value %h invalid %b",
                                       m_axis_tdata, m_axis_tuser));
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.value)
                    note_failure($sformatf("parsed value: expected %h, got %h",
                                           want.value, m_axis_tdata));
                if (m_axis_tuser !== want.invalid)
                    note_failure($sformatf("invalid flag: expected %b, got %b",
                                           want.invalid, m_axis_tuser));
            end
        end
    end

    // Returns the digit value of a character in the given base, or -1 if the
    // character is not a digit of that base. The unused base code is parsed
    // as hex.
    function automatic int digit_value(input logic [1:0] base, input logic [7:0] c);
        logic [7:0] offset;
        offset = c - ASCII_ZERO;
        if (base == BASE_DEC)
            return (c >= ASCII_ZERO && c <= ASCII_NINE) ? int'(offset) : -1;
        if (base == BASE_BIN)
            return (c == ASCII_ZERO || c == ASCII_ONE) ? int'(offset) : -1;
        if (c < ASCII_ZERO)
            return -1;
        if (offset <= DEC_MAX_DIGIT)
            return int'(offset);
        if (offset >= HEX_UPPER_LO && offset <= HEX_UPPER_HI)
            return int'(offset - HEX_UPPER_ADJ);
        if (offset >= HEX_LOWER_LO && offset <= HEX_LOWER_HI)
            return int'(offset - HEX_LOWER_ADJ);
        return -1;
    endfunction

    task automatic clear_model_string();
        model_value = '0;
        model_negative = 1'b0;
        model_error = 1'b0;
        model_at_first = 1'b1;
    endtask

    // This task folds one accepted character into the model. On a closing
    // transaction it queues the expected result and starts a new string.
    task automatic predict_char(input logic [7:0] c, input logic present,
                                input logic last);
        logic first;
        int   d;
        parse_result_t res;
        if (present)
        begin
            first = model_at_first;
            model_at_first = 1'b0;
            if (!model_error)
            begin
                if (first && c == ASCII_MINUS)
                begin
                    model_negative = 1'b1;
                end
                else
                begin
                    d = digit_value(model_base, c);
                    if (d < 0)
                        model_error = 1'b1;
                    else if (model_base == BASE_DEC)
                        model_value = model_value * 32'd10 + 32'(d);
                    else if (model_base == BASE_BIN)
                        model_value = (model_value << 1) + 32'(d);
                    else
                        model_value = (model_value << 4) + 32'(d);
                end
            end
        end
        if (last)
        begin
            res.invalid = model_error;
            if (model_error)
                res.value = '0;
            else
                res.value = model_negative ? -model_value : model_value;
            pending_results.push_back(res);
            clear_model_string();
        end
    endtask

    // This task sends one input transaction. It is entered and left at a
    // falling edge. tvalid stays high when the next item follows with no gap,
    // so it is never lowered and raised in the same step.
    task automatic send_char(input logic [7:0] c, input logic present,
                             input logic last);
        int gap;
        if (src_idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= present;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_char(c, present, last);
        chars_sent++;
        @(negedge clk);
    endtask

    // This task sends a literal string and closes it on its last character.
    // An empty string is sent as a single empty closing item.
    task automatic send_text(input string s);
        if (s.len() == 0)
            send_char(8'h00, 1'b0, 1'b1);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b1, i == s.len() - 1);
    endtask

    // The input is held idle until every queued result has arrived. A further
    // wait of DRAIN_CYCLES then lets any empty trailing items leave the pipeline.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // The base is only changed while no string is in flight.
    task automatic write_base(input logic [1:0] base);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= base;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model_base = base;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_digit_char(input logic [1:0] base);
        int d;
        if (base == BASE_DEC)
            return ASCII_ZERO + 8'($urandom_range(0, 9));
        if (base == BASE_BIN)
            return ASCII_ZERO + 8'($urandom_range(0, 1));
        d = $urandom_range(0, 15);
        if (d <= 9)
            return ASCII_ZERO + 8'(d);
        if ($urandom_range(0, 1) == 0)
            return ASCII_ZERO + HEX_UPPER_ADJ + 8'(d);
        return ASCII_ZERO + HEX_LOWER_ADJ + 8'(d);
    endfunction

    // This task builds and sends one random string. Most strings are well
    // formed with random digits, and about one in eight is long, often long enough to
    // overflow. Some strings carry one bad character, often a minus sign that
    // is not first. The rest are pure noise.
    task automatic send_random_string();
        char_item_t items[$];
        char_item_t it;
        int kind;
        int n_digits;
        int long_len;
        int noise_pos;
        kind = $urandom_range(0, 9);
        if (kind == 9)
        begin
            repeat ($urandom_range(1, 6))
            begin
                it.code = 8'($urandom_range(0, 255));
                it.present = 1'($urandom_range(0, 1));
                it.last = 1'b0;
                items.push_back(it);
            end
        end
        else
        begin
            long_len = (model_base == BASE_BIN) ? 40 : (model_base == BASE_DEC) ? 14 : 12;
            n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(9, long_len)
                                                   : $urandom_range(0, 8);
            noise_pos = (kind >= 7) ? $urandom_range(0, n_digits) : -1;
            it.present = 1'b1;
            it.last = 1'b0;
            if ($urandom_range(0, 3) == 0)
            begin
                it.code = ASCII_MINUS;
                items.push_back(it);
            end
            for (int i = 0; i <= n_digits; i++)
            begin
                if (i == noise_pos)
                begin
                    it.present = 1'b1;
                    it.code = ($urandom_range(0, 2) == 0) ? ASCII_MINUS
                                                          : 8'($urandom_range(0, 255));
                    items.push_back(it);
                end
                // Empty items may fall anywhere inside the string.
                if ($urandom_range(0, 11) == 0)
                begin
                    it.present = 1'b0;
                    it.code = 8'($urandom_range(0, 255));
                    items.push_back(it);
                end
                if (i < n_digits)
                begin
                    it.present = 1'b1;
                    it.code = random_digit_char(model_base);
                    items.push_back(it);
                end
            end
        end
        // The string is closed on its final character or on an empty item.
        if (items.size() == 0 || $urandom_range(0, 1) == 0)
        begin
            it.code = 8'($urandom_range(0, 255));
            it.present = 1'b0;
            it.last = 1'b1;
            items.push_back(it);
        end
        else
        begin
            items[items.size() - 1].last = 1'b1;
        end
        foreach (items[i])
            send_char(items[i].code, items[i].present, items[i].last);
    endtask

    // Decimal is the base after reset, so these strings run before any write
    // to the configuration channel.
    task automatic test_reset_base();
        send_text("-7");
        send_text("");
        send_text("-");
        send_char(8'h00, 1'b1, 1'b1);           // NUL is a bad character
        send_text("1-");                        // minus sign after a digit
        send_char(8'hff, 1'b0, 1'b0);           // empty item keeps the start flag
        send_text("-5");
        send_char(8'hff, 1'b1, 1'b0);           // error, then the digit is ignored
        send_text("3");
    endtask

    task automatic test_each_base();
        write_base(BASE_BIN);
        send_text("10");
        send_text("2");
        write_base(BASE_HEX);
        send_text("fA");
        send_text("g");
        write_base(BASE_UNUSED);
        send_text("9a");
    endtask

    task automatic test_random_base(input logic [1:0] base, input int count,
                                    input bit src_idle, input bit sink_stall);
        int stop_at;
        write_base(base);
        src_idle_en = src_idle;
        sink_stall_en = sink_stall;
        stop_at = chars_sent + count;
        while (chars_sent < stop_at)
            send_random_string();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = BASE_DEC;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        model_base = BASE_DEC;
        clear_model_string();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_base();
        test_each_base();
        test_random_base(BASE_BIN,    PHASE_ITEMS, 1'b1, 1'b1);
        test_random_base(BASE_HEX,    PHASE_ITEMS, 1'b1, 1'b0);
        test_random_base(BASE_DEC,    PHASE_ITEMS, 1'b0, 1'b1);
        test_random_base(BASE_UNUSED, PHASE_ITEMS, 1'b1, 1'b1);
        test_random_base(BASE_BIN,    PHASE_ITEMS, 1'b1, 1'b1);
        test_random_base(BASE_DEC,    PHASE_ITEMS, 1'b0, 1'b0);
        wait_results_drained();

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
design/ampi_pkg.sv
design/ampi_front.sv
design/ampi_queue.sv
design/ampi_back.sv
design/ascii_multibase_integer_parser.sv
test/tb.sv
